/* src/set_of_bounded_stacks_top_defines.svh */
// ----------------------------------------------------------------------------
// set_of_bounded_stacks_top_defines
// Assertion macros used by the bounded stack set controller.
// ----------------------------------------------------------------------------
`ifndef SET_OF_BOUNDED_STACKS_TOP_DEFINES_SVH
`define SET_OF_BOUNDED_STACKS_TOP_DEFINES_SVH

// same-cycle implication under synchronous reset
`define SBS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sbs assertion failed");

// next-cycle implication under synchronous reset
`define SBS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sbs assertion failed");

`endif

/* src/sbs_pkg.sv */
// ----------------------------------------------------------------------------
// sbs_pkg
// Types, sizes and codes for the bounded stack set.
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

  localparam int MAX_STACKS  = 16;
  localparam int STACK_DEPTH = 8;

  localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int NUM_W  = $clog2(MAX_STACKS + 1);
  localparam int ADDR_W = (MAX_STACKS * STACK_DEPTH > 1) ?
                          $clog2(MAX_STACKS * STACK_DEPTH) : 1;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 4;
  localparam int IDX_W  = 4;
  localparam int CMP_W  = FILL_W + CAP_W;
  localparam int IXC_W  = NUM_W + IDX_W;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_POP_AT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_OPEN,
    ST_READ
  } sbs_state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [WORD_W-1:0] push_value;
    logic [IDX_W-1:0]        stack_index;
  } sbs_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [1:0]              status;
  } sbs_out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } sbs_ram_req_t;

  function automatic logic [ADDR_W-1:0] sbs_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [FILL_W-1:0] off);
    sbs_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(STACK_DEPTH) + ADDR_W'(off));
  endfunction

endpackage

`default_nettype wire

/* src/sbs_word_ram.sv */
// ----------------------------------------------------------------------------
// sbs_word_ram
// Word store for all stack slots, one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_word_ram (
  input  wire logic                         clk,
  input  wire sbs_pkg::sbs_ram_req_t        req,
  output logic [sbs_pkg::WORD_W-1:0]        rdata
);
  import sbs_pkg::*;

  logic [WORD_W-1:0] mem [MAX_STACKS*STACK_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/sbs_ctrl.sv */
// ----------------------------------------------------------------------------
// sbs_ctrl
// Sequencer for push, pop and pop-at: slot order, fill counts, word store
// accesses and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_of_bounded_stacks_top_defines.svh"

module sbs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire sbs_pkg::sbs_in_t             in_item,
  input  wire logic [sbs_pkg::FILL_W-1:0]   eff_cap,
  output sbs_pkg::sbs_ram_req_t             ram_req,
  input  wire logic [sbs_pkg::WORD_W-1:0]   ram_rdata,
  output logic                              out_valid,
  output sbs_pkg::sbs_out_t                 out_item
);
  import sbs_pkg::*;

  sbs_state_t        state_r, state_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  logic [SLOT_W-1:0] order_r [MAX_STACKS];
  logic [SLOT_W-1:0] order_nxt [MAX_STACKS];
  logic [FILL_W-1:0] fill_r [MAX_STACKS];
  logic [FILL_W-1:0] fill_nxt [MAX_STACKS];
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic              push_r, push_nxt;
  logic              out_valid_r, out_valid_nxt;
  sbs_out_t          out_item_r, out_item_nxt;

  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] top;
  logic              accept;
  logic              set_empty;
  logic              bad_index;
  logic              has_room;
  logic              all_used;

  assign accept    = start && (state_r == ST_IDLE);
  assign slot      = order_r[pos_r];
  assign fill      = fill_r[slot];
  assign top       = fill - FILL_W'(1);
  assign set_empty = (n_r == '0);
  assign bad_index = IXC_W'(in_item.stack_index) >= IXC_W'(n_r);
  assign has_room  = fill < eff_cap;
  assign all_used  = (n_r == NUM_W'(MAX_STACKS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_item.command)
            CMD_PUSH:   state_nxt = set_empty ? ST_OPEN : ST_SLOT;
            CMD_POP:    state_nxt = set_empty ? ST_IDLE : ST_SLOT;
            CMD_POP_AT: state_nxt = (set_empty || bad_index) ? ST_IDLE : ST_SLOT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SLOT: begin
        if (!push_r) begin
          state_nxt = ST_READ;
        end else if (has_room || all_used) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_OPEN;
        end
      end
      ST_OPEN: state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    n_nxt         = n_r;
    order_nxt     = order_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    push_nxt      = push_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt  = in_item.push_value;
          push_nxt = (in_item.command == CMD_PUSH);
          unique case (in_item.command)
            CMD_PUSH: begin
              pos_nxt = set_empty ? '0 : SLOT_W'(n_r - NUM_W'(1));
            end
            CMD_POP: begin
              pos_nxt = SLOT_W'(n_r - NUM_W'(1));
              if (set_empty) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{popped_value: '0, status: STAT_EMPTY};
              end
            end
            CMD_POP_AT: begin
              pos_nxt = SLOT_W'(in_item.stack_index);
              if (set_empty || bad_index) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{popped_value: '0,
                                  status: set_empty ? STAT_EMPTY : STAT_BAD_INDEX};
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{popped_value: '0, status: STAT_OK};
            end
          endcase
        end
      end
      ST_SLOT: begin
        if (push_r) begin
          if (has_room) begin
            ram_req        = '{we: 1'b1, re: 1'b0, addr: sbs_addr(slot, fill), wdata: val_r};
            fill_nxt[slot] = fill + FILL_W'(1);
            out_valid_nxt  = 1'b1;
            out_item_nxt   = '{popped_value: '0, status: STAT_OK};
          end else if (all_used) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{popped_value: '0, status: STAT_FULL};
          end else begin
            pos_nxt = SLOT_W'(n_r);
          end
        end else begin
          ram_req        = '{we: 1'b0, re: 1'b1, addr: sbs_addr(slot, top), wdata: '0};
          fill_nxt[slot] = top;
          if (top == '0) begin
            // close up the order behind the emptied stack
            for (int i = 0; i < MAX_STACKS - 1; i++) begin
              if ((SLOT_W'(i) >= pos_r) && (NUM_W'(i + 1) < n_r)) begin
                order_nxt[i] = order_r[i+1];
              end
            end
            order_nxt[SLOT_W'(n_r - NUM_W'(1))] = slot;
            n_nxt = n_r - NUM_W'(1);
          end
        end
      end
      ST_OPEN: begin
        ram_req        = '{we: 1'b1, re: 1'b0, addr: sbs_addr(slot, '0), wdata: val_r};
        fill_nxt[slot] = FILL_W'(1);
        n_nxt          = n_r + NUM_W'(1);
        out_valid_nxt  = 1'b1;
        out_item_nxt   = '{popped_value: '0, status: STAT_OK};
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{popped_value: ram_rdata, status: STAT_OK};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        order_r[i] <= SLOT_W'(i);
        fill_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      order_r     <= order_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    push_r     <= push_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SBS_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || out_valid_r)
  `SBS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, n_r <= NUM_W'(MAX_STACKS))
  `SBS_ASSERT_NOW(a_write_states, clk, rst_n, ram_req.we,
                  state_r == ST_SLOT || state_r == ST_OPEN)
  `SBS_ASSERT_NOW(a_read_follows_slot, clk, rst_n, state_r == ST_READ,
                  $past(state_r) == ST_SLOT && $past(ram_req.re))
  `SBS_ASSERT_NEXT(a_open_grows, clk, rst_n, state_r == ST_OPEN,
                   n_r == $past(n_r) + NUM_W'(1))

endmodule

`default_nettype wire

/* src/set_of_bounded_stacks_top.sv */
// ----------------------------------------------------------------------------
// set_of_bounded_stacks_top
// Ordered set of bounded stacks with push, pop and pop-at.
//
//   channel  ports                          handshake
//   input    start, busy, in_item           taken when start && !busy
//   result   out_valid, out_item            one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_wdata              stack capacity, written on cfg_we
//
// Paths from idle: an unused command, an empty set or a bad index finish in
// idle; a push onto the last stack or a dropped push passes slot; a push into
// an empty set passes open; a push that opens a stack behind a full one passes
// slot and open; a pop or pop-at passes slot and read, as the word store's read
// data is registered. The result strobe is registered and comes as the item
// returns to idle, while the next item can already be taken.
// Reset is synchronous and needs no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module set_of_bounded_stacks_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sbs_pkg::sbs_in_t            in_item,
  output logic                             out_valid,
  output sbs_pkg::sbs_out_t                out_item,
  input  wire logic                        cfg_we,
  input  wire logic [sbs_pkg::CAP_W-1:0]   cfg_wdata
);
  import sbs_pkg::*;

  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [FILL_W-1:0] eff_cap;
  sbs_ram_req_t      ram_req;
  logic [WORD_W-1:0] ram_rdata;

  assign cap_nxt = cfg_we ? cfg_wdata : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = FILL_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(STACK_DEPTH)) begin
      eff_cap = FILL_W'(STACK_DEPTH);
    end else begin
      eff_cap = FILL_W'(cap_r);
    end
  end

  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .eff_cap   (eff_cap),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  sbs_word_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
